FILE: hdl/rrq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrq_pkg
// Shared types, codes and sizes for the round-robin run queue.
// ----------------------------------------------------------------------------
package rrq_pkg;

    localparam int QUEUE_DEPTH   = 16;
    localparam int SLOT_ID_WIDTH = 16;
    localparam int PROC_W        = 22;
    localparam int MODE_W        = 3;
    localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);

    typedef logic [SLOT_ID_WIDTH-1:0] slot_t;
    typedef logic [PROC_W-1:0]        proc_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    // Operation codes; the first five match the request mode field
    typedef enum logic [MODE_W-1:0] {
        OP_PUSH       = 3'd0,
        OP_POP        = 3'd1,
        OP_ERASE_SLOT = 3'd2,
        OP_ERASE_PROC = 3'd3,
        OP_ROTATE     = 3'd4,
        OP_NONE       = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        slot_t slot;
        proc_t proc;
    } entry_t;

    // Broadcast command seen by every cell in the chain
    typedef struct packed {
        op_t    op;
        slot_t  key_slot;
        proc_t  key_proc;
        entry_t push_entry;
        entry_t head_entry;
    } cell_cmd_t;

endpackage
`default_nettype wire

FILE: hdl/rrq_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrq_req_if
// Request channel: operation mode, process id and slot key.
// ----------------------------------------------------------------------------
interface rrq_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [21:0] proc_id;
    logic [15:0] key_slot;

    modport source (output valid, output mode, output proc_id, output key_slot,
                    input ready);
    modport sink   (input valid, input mode, input proc_id, input key_slot,
                    output ready);
endinterface
`default_nettype wire

FILE: hdl/rrq_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrq_rsp_if
// Response channel: status, affected entry and occupancy.
// ----------------------------------------------------------------------------
interface rrq_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] entry_slot;
    logic [21:0] entry_proc;
    logic [4:0]  occupancy;

    modport source (output valid, output status, output entry_slot,
                    output entry_proc, output occupancy, input ready);
    modport sink   (input valid, input status, input entry_slot,
                    input entry_proc, input occupancy, output ready);
endinterface
`default_nettype wire

FILE: hdl/round_robin_run_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// A result beat is registered into the output register, or into the skid
// register on a response stall. One request per cycle while the skid is empty:
// cells ripple the key compare from head to tail combinationally, then shift.
// A two-deep output stage (result register plus skid) keeps taking requests
// for one beat while the response side stalls.
// Reset clears the queue, the occupancy count and the slot id counter at once.
// ----------------------------------------------------------------------------
// round_robin_run_queue
// Ordered run queue with push, pop, keyed erase and rotate, built as a row of
// cells with the head at cell zero.
// ----------------------------------------------------------------------------
module round_robin_run_queue (
    input  logic      clk,
    input  logic      rst_n,
    rrq_req_if.sink   req,
    rrq_rsp_if.source rsp
);
    import rrq_pkg::*;

    typedef struct packed {
        status_t status;
        slot_t   slot;
        proc_t   proc;
        cnt_t    occ;
    } result_t;

    cell_cmd_t cmd;
    op_t       op;
    logic      accept;

    logic   [QUEUE_DEPTH-1:0] cell_valid;
    entry_t [QUEUE_DEPTH-1:0] cell_entry;
    logic   [QUEUE_DEPTH-1:0] cell_chain;
    logic   [QUEUE_DEPTH-1:0] cell_hit;

    cnt_t    count_reg;
    cnt_t    count_next;
    slot_t   next_slot_reg;
    slot_t   next_slot_next;
    result_t res;
    entry_t  erase_entry;
    logic    full;
    logic    empty;
    logic    found;

    logic    out_valid_reg;
    result_t out_reg;
    logic    skid_valid_reg;
    result_t skid_reg;

    assign req.ready = !skid_valid_reg;
    assign accept    = req.valid && req.ready;

    // Decode mode
    always_comb
    begin
        if (req.mode <= MODE_W'(OP_ROTATE))
        begin
            op = op_t'(req.mode);
        end
        else
        begin
            op = OP_NONE;
        end
    end

    // Broadcast command to the chain
    always_comb
    begin
        cmd.op              = accept ? op : OP_NONE;
        cmd.key_slot        = slot_t'(req.key_slot);
        cmd.key_proc        = req.proc_id;
        cmd.push_entry.slot = next_slot_reg;
        cmd.push_entry.proc = req.proc_id;
        cmd.head_entry      = cell_entry[0];
    end

    // Build the row of cells
    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            logic   left_v;
            logic   chain_i;
            logic   right_v;
            entry_t right_e;

            if (gi == 0)
            begin : g_head
                assign left_v  = 1'b1;
                assign chain_i = 1'b0;
            end
            else
            begin : g_mid
                assign left_v  = cell_valid[gi-1];
                assign chain_i = cell_chain[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_last
                assign right_v = 1'b0;
                assign right_e = '0;
            end
            else
            begin : g_inner
                assign right_v = cell_valid[gi+1];
                assign right_e = cell_entry[gi+1];
            end

            rrq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .left_valid  (left_v),
                .chain_in    (chain_i),
                .right_valid (right_v),
                .right_entry (right_e),
                .valid       (cell_valid[gi]),
                .entry       (cell_entry[gi]),
                .chain_out   (cell_chain[gi]),
                .hit         (cell_hit[gi])
            );
        end
    endgenerate

    // Select the first matching entry
    always_comb
    begin
        erase_entry = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (cell_hit[i] && ((i == 0) || !cell_chain[(i == 0) ? 0 : i - 1]))
            begin
                erase_entry = erase_entry | cell_entry[i];
            end
        end
    end

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign found = cell_chain[QUEUE_DEPTH-1];

    // Form the result and next count
    always_comb
    begin
        res.status     = ST_OK;
        res.slot       = '0;
        res.proc       = '0;
        count_next     = count_reg;
        next_slot_next = next_slot_reg;
        case (op)
            OP_PUSH:
            begin
                if (full)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    res.slot       = next_slot_reg;
                    res.proc       = req.proc_id;
                    count_next     = count_reg + CNT_W'(1);
                    next_slot_next = next_slot_reg + SLOT_ID_WIDTH'(1);
                end
            end
            OP_POP:
            begin
                if (empty)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    res.slot   = cell_entry[0].slot;
                    res.proc   = cell_entry[0].proc;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_ERASE_SLOT, OP_ERASE_PROC:
            begin
                if (empty)
                begin
                    res.status = ST_EMPTY;
                end
                else if (!found)
                begin
                    res.status = ST_NOT_FOUND;
                end
                else
                begin
                    res.slot   = erase_entry.slot;
                    res.proc   = erase_entry.proc;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_ROTATE:
            begin
                if (empty)
                begin
                    res.status = ST_EMPTY;
                end
                else if (count_reg == CNT_W'(1))
                begin
                    res.slot = cell_entry[0].slot;
                    res.proc = cell_entry[0].proc;
                end
                else
                begin
                    res.slot = cell_entry[1].slot;
                    res.proc = cell_entry[1].proc;
                end
            end
            default:
            begin
                res.status = ST_OK;
            end
        endcase
        res.occ = count_next;
    end

    // Hold count and slot id counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            next_slot_reg <= '0;
        end
        else if (accept)
        begin
            count_reg     <= count_next;
            next_slot_reg <= next_slot_next;
        end
    end

    // Output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (out_valid_reg && !rsp.ready)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (rsp.ready)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    // Result payload beats
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (out_valid_reg && !rsp.ready)
            begin
                skid_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
        else if (rsp.ready && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_reg.status;
    assign rsp.entry_slot = out_reg.slot[15:0];
    assign rsp.entry_proc = out_reg.proc;
    assign rsp.occupancy  = out_reg.occ;

    // Occupied cells form a run starting at the head
    a_valid_run : assert property (@(posedge clk) disable iff (!rst_n)
        (cell_valid & (cell_valid + QUEUE_DEPTH'(1))) == '0)
        else $error("queue cells are not contiguous from the head");

    // Count tracks the occupied cells
    a_count_match : assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) == int'(count_reg))
        else $error("occupancy count disagrees with cell valid bits");

    // Skid stage only fills behind a waiting result
    a_skid_behind : assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid beat held without an output beat");

    // Accepted push into a non-full queue grows it by one
    a_push_grows : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op == OP_PUSH) && !full) |=>
        (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("push did not add an entry");

endmodule
`default_nettype wire

FILE: hdl/rrq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrq_cell
// One queue position: holds an entry and its valid bit, loads on push at the
// tail, takes the right neighbor's entry on removal, and feeds the head
// entry back in at the tail on rotate.
// ----------------------------------------------------------------------------
module rrq_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  rrq_pkg::cell_cmd_t cmd,
    input  logic              left_valid,
    input  logic              chain_in,
    input  logic              right_valid,
    input  rrq_pkg::entry_t   right_entry,
    output logic              valid,
    output rrq_pkg::entry_t   entry,
    output logic              chain_out,
    output logic              hit
);
    import rrq_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    entry_t entry_reg;
    entry_t entry_next;
    logic   is_tail;

    // Match against the erase key
    assign hit = valid_reg &&
                 (((cmd.op == OP_ERASE_SLOT) && (entry_reg.slot == cmd.key_slot)) ||
                  ((cmd.op == OP_ERASE_PROC) && (entry_reg.proc == cmd.key_proc)));

    // Removal point ripples toward the tail
    assign chain_out = chain_in || hit;
    assign is_tail   = valid_reg && !right_valid;

    // Choose next contents
    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        case (cmd.op)
            OP_PUSH:
            begin
                if (!valid_reg && left_valid)
                begin
                    valid_next = 1'b1;
                    entry_next = cmd.push_entry;
                end
            end
            OP_POP:
            begin
                valid_next = right_valid;
                entry_next = right_entry;
            end
            OP_ERASE_SLOT, OP_ERASE_PROC:
            begin
                if (chain_out)
                begin
                    valid_next = right_valid;
                    entry_next = right_entry;
                end
            end
            OP_ROTATE:
            begin
                entry_next = is_tail ? cmd.head_entry : right_entry;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    // Hold valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold entry payload
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign valid = valid_reg;
    assign entry = entry_reg;

endmodule
`default_nettype wire

FILE: sim/rrq_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrq_scoreboard
// Watches the request and result channels of the run queue, keeps its own
// copy of the queue and checks every result beat, in order, against it.
// ----------------------------------------------------------------------------
module rrq_scoreboard
    import rrq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    rrq_req_if   req,
    rrq_rsp_if   rsp,
    output int   error_count,
    output int   pending_count
);

    typedef struct packed {
        status_t status;
        slot_t   slot;
        proc_t   proc;
        cnt_t    occ;
    } result_t;

    // Shadow queue, head at index zero
    slot_t   run_slots [QUEUE_DEPTH];
    proc_t   run_procs [QUEUE_DEPTH];
    int      run_len = 0;
    slot_t   slot_counter = '0;
    result_t pending_results [$];

    // Close the gap left by a removed entry
    task automatic unlink_entry(input int pos);
        for (int i = pos; i + 1 < run_len; i++)
        begin
            run_slots[i] = run_slots[i + 1];
            run_procs[i] = run_procs[i + 1];
        end
        run_len--;
    endtask

    // Apply one request beat to the shadow queue and build its result
    task automatic predict_result(input logic [MODE_W-1:0] mode, input proc_t pid,
                                  input slot_t key, output result_t res);
        int    hit;
        slot_t head_slot;
        proc_t head_proc;
        res = '{status: ST_OK, slot: '0, proc: '0, occ: '0};
        hit = -1;
        if (mode == OP_PUSH)
        begin
            if (run_len == QUEUE_DEPTH)
                res.status = ST_FULL;
            else
            begin
                run_slots[run_len] = slot_counter;
                run_procs[run_len] = pid;
                res.slot = slot_counter;
                res.proc = pid;
                run_len++;
                slot_counter = slot_counter + 1'b1;
            end
        end
        else if (mode <= OP_ROTATE)
        begin
            if (run_len == 0)
                res.status = ST_EMPTY;
            else if (mode == OP_POP)
            begin
                res.slot = run_slots[0];
                res.proc = run_procs[0];
                unlink_entry(0);
            end
            else if (mode == OP_ROTATE)
            begin
                head_slot = run_slots[0];
                head_proc = run_procs[0];
                for (int i = 0; i + 1 < run_len; i++)
                begin
                    run_slots[i] = run_slots[i + 1];
                    run_procs[i] = run_procs[i + 1];
                end
                run_slots[run_len - 1] = head_slot;
                run_procs[run_len - 1] = head_proc;
                res.slot = run_slots[0];
                res.proc = run_procs[0];
            end
            else
            begin
                // First match counted from the head
                for (int i = 0; i < run_len && hit < 0; i++)
                begin
                    if (mode == OP_ERASE_SLOT ? run_slots[i] == key : run_procs[i] == pid)
                        hit = i;
                end
                if (hit < 0)
                    res.status = ST_NOT_FOUND;
                else
                begin
                    res.slot = run_slots[hit];
                    res.proc = run_procs[hit];
                    unlink_entry(hit);
                end
            end
        end
        res.occ = cnt_t'(run_len);
    endtask

    // Check result beats first: a request beat never answers at its own edge
    always @(posedge clk)
    begin : watch
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            run_len = 0;
            slot_counter = '0;
            pending_results.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got = '{status: status_t'(rsp.status), slot: rsp.entry_slot,
                        proc: rsp.entry_proc, occ: rsp.occupancy};
                if (pending_results.size() == 0)
                begin
                    if (error_count < 10)
                        $display("unexpected result beat at %0t: status %0d slot %h proc %h",
                                 $time, got.status, got.slot, got.proc);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got != want)
                    begin
                        if (error_count < 10)
                        begin
                            $display("mismatch %0t: want status %0d slot %h proc %h occ %0d",
                                     $time, want.status, want.slot, want.proc, want.occ);
                            $display("mismatch %0t: got  status %0d slot %h proc %h occ %0d",
                                     $time, got.status, got.slot, got.proc, got.occ);
                        end
                        error_count++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                predict_result(req.mode, req.proc_id, req.key_slot, want);
                pending_results.push_back(want);
            end
        end
        pending_count = pending_results.size();
    end

endmodule

FILE: sim/round_robin_run_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_run_queue_tb
// Drives push, pop, keyed erase, rotate and unused modes into the run queue,
// first a directed sequence, then random traffic under changing idle and
// stall patterns; the scoreboard checks every result beat.
// ----------------------------------------------------------------------------
module round_robin_run_queue_tb;
    import rrq_pkg::*;

    localparam int PHASE_ITEMS = 280;
    localparam int POOL_SIZE   = 8;

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    int        error_count;
    int        pending_count;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    int        hold_request   = 0;
    slot_t     newest_slot    = '0;
    proc_t     pid_pool [POOL_SIZE];

    rrq_req_if req_ch ();
    rrq_rsp_if rsp_ch ();

    round_robin_run_queue dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    rrq_scoreboard scoreboard (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Track the newest slot id handed out, to aim erase keys at live entries
    always @(posedge clk)
    begin
        if (rsp_ch.valid && rsp_ch.ready && rsp_ch.status == ST_OK
            && rsp_ch.entry_slot > newest_slot)
            newest_slot <= rsp_ch.entry_slot;
    end

    // Result side: random stalls, plus long hold-offs on request
    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one request beat and hold it until accepted
    task automatic offer_op(input logic [MODE_W-1:0] mode, input proc_t pid,
                            input slot_t key);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.mode     <= mode;
        req_ch.proc_id  <= pid;
        req_ch.key_slot <= key;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    // Drop valid and wait until every expected result beat has come back
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0)
            @(negedge clk);
    endtask

    // Mostly keys that hit live entries, some noise and unused modes
    task automatic random_op(input int push_pct);
        int    pick;
        proc_t pid;
        slot_t key;
        pid = ($urandom_range(99) < 70) ? pid_pool[$urandom_range(POOL_SIZE - 1)]
                                        : proc_t'($urandom);
        key = ($urandom_range(99) < 75) ? slot_t'(newest_slot - $urandom_range(20))
                                        : slot_t'($urandom);
        pick = $urandom_range(99);
        if (pick < 3)
            offer_op(MODE_W'($urandom_range((1 << MODE_W) - 1, OP_NONE)), pid, key);
        else if ($urandom_range(99) < push_pct)
            offer_op(OP_PUSH, pid, key);
        else
        begin
            pick = $urandom_range(9);
            if (pick < 2)
                offer_op(OP_POP, pid, key);
            else if (pick < 5)
                offer_op(OP_ERASE_SLOT, pid, key);
            else if (pick < 8)
                offer_op(OP_ERASE_PROC, pid, key);
            else
                offer_op(OP_ROTATE, pid, key);
        end
    endtask

    initial
    begin : stimulus
        req_ch.valid    = 1'b0;
        req_ch.mode     = OP_PUSH;
        req_ch.proc_id  = '0;
        req_ch.key_slot = '0;
        rsp_ch.ready    = 1'b0;
        pid_pool[0] = '0;
        pid_pool[1] = '1;
        pid_pool[2] = 22'h2AAAAA;
        pid_pool[3] = 22'h155555;
        for (int i = 4; i < POOL_SIZE; i++)
            pid_pool[i] = proc_t'($urandom);

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Every removal and rotate on an empty queue, then an unused mode
        offer_op(OP_POP, '1, '1);
        offer_op(OP_ROTATE, '0, '0);
        offer_op(OP_ERASE_SLOT, '0, '0);
        offer_op(OP_ERASE_PROC, '1, '1);
        offer_op({MODE_W{1'b1}}, '1, '1);

        // Fill to the brim with repeated process ids, then push once more
        for (int i = 0; i < QUEUE_DEPTH; i++)
            offer_op(OP_PUSH, pid_pool[i % POOL_SIZE], '0);
        offer_op(OP_PUSH, 22'h123456, '0);

        // Rotate, keyed erase with and without a match, pop
        offer_op(OP_ROTATE, '0, '0);
        offer_op(OP_ERASE_SLOT, '0, slot_t'(5));
        offer_op(OP_ERASE_SLOT, '0, '1);
        offer_op(OP_ERASE_PROC, pid_pool[2], '0);
        offer_op(OP_ERASE_PROC, 22'h0F0F0F, '0);
        offer_op(OP_POP, '0, '0);
        drain_results();

        // Random traffic under four idle patterns
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 9;  recv_stall_pct = 9;  end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Back up the result side while requests keep coming
                if (phase == 0 && n == 120)
                    hold_request = 80;
                if (phase == 1 && n == 140)
                    drain_results();
                // Alternate fill-heavy and drain-heavy stretches
                random_op(((n / 40) % 2 == 1) ? 30 : 70);
            end
            drain_results();
        end

        repeat (4) @(posedge clk);
        if (error_count == 0 && pending_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : watchdog
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
